// ===== rtl/core/mbgs_pkg.sv =====
package mbgs_pkg;

  // grid geometry (64 x 64 cells, row-major address {row, column})
  localparam int GRID_W_BITS = 6;
  localparam int GRID_H_BITS = 6;
  localparam int ADDR_W      = GRID_W_BITS + GRID_H_BITS;
  localparam int MEM_DEPTH   = 1 << ADDR_W;

  // field widths
  localparam int DIST_W     = 16;
  localparam int POS_W      = 24;
  localparam int REL_W      = POS_W + 1;
  localparam int INV_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int GRID_POS_W = 34;
  localparam int T_W        = FRAC_W + 1;
  localparam int CELL_W     = GRID_W_BITS + 2;
  localparam int W_W        = 2 * FRAC_W + 1;
  localparam int SUM_W      = DIST_W + 2 * FRAC_W;
  localparam int NUM_W      = SUM_W + 1;
  localparam int QUO_W      = DIST_W;
  localparam int QUO_CNT_W  = $clog2(QUO_W + 1);

  // shared multiplier operands and product
  localparam int MUL_A_W = GRID_POS_W;
  localparam int MUL_B_W = INV_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Q.16 constants
  localparam logic [T_W-1:0] ONE_Q16  = T_W'(65536);
  localparam logic [T_W-1:0] HALF_Q16 = T_W'(32768);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X    = 3'd0,
    CFG_OFFSET_Y    = 3'd1,
    CFG_INV_TILE_W  = 3'd2,
    CFG_UNREACHED   = 3'd3,
    CFG_FIELD_READY = 3'd4
  } cfg_reg_t;

  // request kinds carried in tuser
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_LATCH_Y,
    ST_SETUP,
    ST_NB_ADDR,
    ST_NB_READ,
    ST_NB_WMUL,
    ST_NB_ACC,
    ST_FINISH,
    ST_CENTER,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/core/mbgs_div.sv =====
module mbgs_div
  import mbgs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [W_W-1:0]     den,
  output div_status_t        status,
  output logic [QUO_W-1:0]   quot
);

  // restoring division, one quotient bit per cycle; num < den * 2^16 is given
  logic [W_W-1:0]       rem;
  logic [QUO_W-1:0]     shreg;
  logic [QUO_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [W_W:0]   trial;
  logic [W_W+1:0] diff;
  logic           ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, shreg[QUO_W-1]};
    diff  = {1'b0, trial} - {2'b00, den};
    ge    = ~diff[W_W+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= QUO_CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - QUO_CNT_W'(1);
        if (cnt == QUO_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:QUO_W];
      shreg <= num[QUO_W-1:0];
    end else if (busy) begin
      rem   <= ge ? diff[W_W-1:0] : trial[W_W-1:0];
      shreg <= {shreg[QUO_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot        = shreg;

endmodule

// ===== rtl/core/masked_bilinear_grid_sample.sv =====
// Masked bilinear sampler over a 64 x 64 grid of Q12.4 distances. After reset the block
// runs a clearing pass that fills every cell with 65535, and takes no transaction
// meanwhile (configuration writes are taken). A write transaction (tuser = 0) stores one
// cell and gives no result. A query transaction (tuser = 1) gives exactly one result: 0
// when field_ready is low or when the point falls outside the grid, the centre cell when
// no neighbour counts, otherwise the bilinear blend of the reached, in-grid neighbours,
// rounded to nearest. The blend path is long because one multiplier is shared for the two
// position scalings and for two products per neighbour over four neighbours read one at a
// time through the single read port of the grid memory, and a 16-step serial divider
// normalizes the weighted sum. A finished result waits in the output register while the
// next transaction is taken; a query that finishes while that result is still not taken
// holds in its last step until the receiver takes that result.
module masked_bilinear_grid_sample
  import mbgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [79:0]           s_axis_tdata,  // tile_x, tile_y, new_distance, pos_x, pos_y
  input  logic                  s_axis_tuser,  // req_type
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // interp_distance
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  // configuration registers
  logic [POS_W-1:0]  offset_x;
  logic [POS_W-1:0]  offset_y;
  logic [INV_W-1:0]  inv_tile_width;
  logic [DIST_W-1:0] unreached_distance;
  logic              field_ready;

  // input unpacking
  logic [GRID_W_BITS-1:0] in_tile_x;
  logic [GRID_H_BITS-1:0] in_tile_y;
  logic [DIST_W-1:0]      in_new_distance;
  logic [POS_W-1:0]       in_pos_x;
  logic [POS_W-1:0]       in_pos_y;
  logic                   in_accept;

  // query datapath
  logic [POS_W-1:0]             pos_x;
  logic [POS_W-1:0]             pos_y;
  logic signed [REL_W-1:0]      rel_x;
  logic signed [REL_W-1:0]      rel_y;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]     prod;
  logic [GRID_POS_W-1:0]        gx;
  logic [GRID_POS_W-1:0]        gy;
  logic                         grid_hit;
  logic                         x_beyond;
  logic                         y_beyond;
  logic [GRID_W_BITS-1:0]       cx;
  logic [GRID_H_BITS-1:0]       cy;
  logic signed [CELL_W-1:0]     bx;
  logic signed [CELL_W-1:0]     by;
  logic [T_W-1:0]               tx;
  logic [T_W-1:0]               ty;
  logic [1:0]                   nb_k;
  logic signed [CELL_W-1:0]     nx;
  logic signed [CELL_W-1:0]     ny;
  logic [T_W-1:0]               wx;
  logic [T_W-1:0]               wy;
  logic                         nb_in;
  logic                         nb_use;
  logic [DIST_W-1:0]            nb_dist;
  logic [W_W-1:0]               weight;
  logic [SUM_W-1:0]             sum;
  logic [W_W-1:0]               wsum;
  logic [DIST_W-1:0]            result;

  // grid memory
  logic [DIST_W-1:0] mem [MEM_DEPTH];
  logic [ADDR_W-1:0] clr_cnt;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DIST_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DIST_W-1:0] mem_rdata;

  // divider
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  div_status_t       div_stat;
  logic [QUO_W-1:0]  div_quot;

  // output register
  logic              out_load;

  assign in_tile_x       = s_axis_tdata[5:0];
  assign in_tile_y       = s_axis_tdata[11:6];
  assign in_new_distance = s_axis_tdata[27:12];
  assign in_pos_x        = s_axis_tdata[51:28];
  assign in_pos_y        = s_axis_tdata[75:52];
  assign in_accept       = s_axis_tvalid & s_axis_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x           <= '0;
      offset_y           <= '0;
      inv_tile_width     <= INV_W'(65536);
      unreached_distance <= '1;
      field_ready        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_X:    offset_x           <= cfg_data[POS_W-1:0];
        CFG_OFFSET_Y:    offset_y           <= cfg_data[POS_W-1:0];
        CFG_INV_TILE_W:  inv_tile_width     <= cfg_data[INV_W-1:0];
        CFG_UNREACHED:   unreached_distance <= cfg_data[DIST_W-1:0];
        CFG_FIELD_READY: field_ready        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // position relative to grid origin
  assign rel_x = $signed({pos_x[POS_W-1], pos_x}) - $signed({offset_x[POS_W-1], offset_x});
  assign rel_y = $signed({pos_y[POS_W-1], pos_y}) - $signed({offset_y[POS_W-1], offset_y});

  // cell selection from the scaled position
  always_comb begin
    grid_hit = (gx[GRID_POS_W-1:FRAC_W+GRID_W_BITS] == '0) &&
               (gy[GRID_POS_W-1:FRAC_W+GRID_H_BITS] == '0);
    x_beyond = gx[FRAC_W-1:0] > HALF_Q16[FRAC_W-1:0];
    y_beyond = gy[FRAC_W-1:0] > HALF_Q16[FRAC_W-1:0];
  end

  // current neighbour and its weights
  always_comb begin
    nx = bx + $signed({{(CELL_W-1){1'b0}}, nb_k[0]});
    ny = by + $signed({{(CELL_W-1){1'b0}}, nb_k[1]});
    wx = nb_k[0] ? tx : ONE_Q16 - tx;
    wy = nb_k[1] ? ty : ONE_Q16 - ty;
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_X: begin
        mul_a = MUL_A_W'(rel_x);
        mul_b = $signed({1'b0, inv_tile_width});
      end
      ST_MUL_Y: begin
        mul_a = MUL_A_W'(rel_y);
        mul_b = $signed({1'b0, inv_tile_width});
      end
      ST_NB_READ: begin
        mul_a = $signed({{(MUL_A_W-T_W){1'b0}}, wx});
        mul_b = $signed({1'b0, wy});
      end
      ST_NB_WMUL: begin
        mul_a = $signed({1'b0, prod[W_W-1:0]});
        mul_b = $signed({2'b00, nb_dist});
      end
      default: ;
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // grid memory: one write port, one registered read port
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '1;
    end else begin
      mem_we    = in_accept && (s_axis_tuser == REQ_WRITE);
      mem_waddr = {in_tile_y, in_tile_x};
      mem_wdata = in_new_distance;
    end
    if (state == ST_FINISH) begin
      mem_raddr = {cy, cx};
    end else begin
      mem_raddr = {ny[GRID_H_BITS-1:0], nx[GRID_W_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // divider numerator with rounding term
  assign div_num = NUM_W'(sum) + NUM_W'(wsum[W_W-1:1]);

  mbgs_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (wsum),
    .status (div_stat),
    .quot   (div_quot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == REQ_QUERY)) begin
          state_next = field_ready ? ST_MUL_X : ST_DONE;
        end
      end
      ST_MUL_X:   state_next = ST_MUL_Y;
      ST_MUL_Y:   state_next = ST_LATCH_Y;
      ST_LATCH_Y: state_next = ST_SETUP;
      ST_SETUP: begin
        state_next = grid_hit ? ST_NB_ADDR : ST_DONE;
      end
      ST_NB_ADDR: state_next = ST_NB_READ;
      ST_NB_READ: state_next = ST_NB_WMUL;
      ST_NB_WMUL: state_next = ST_NB_ACC;
      ST_NB_ACC: begin
        state_next = (nb_k == 2'd3) ? ST_FINISH : ST_NB_ADDR;
      end
      ST_FINISH: begin
        if (wsum != '0) begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_CENTER;
        end
      end
      ST_CENTER:  state_next = ST_DONE;
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // query datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pos_x  <= in_pos_x;
        pos_y  <= in_pos_y;
        result <= '0;
      end
      ST_MUL_Y: begin
        gx <= prod[GRID_POS_W+7:8];
      end
      ST_LATCH_Y: begin
        gy <= prod[GRID_POS_W+7:8];
      end
      ST_SETUP: begin
        // centre cell, lower-left neighbour and fractions toward the upper-right one
        cx   <= gx[FRAC_W+GRID_W_BITS-1:FRAC_W];
        cy   <= gy[FRAC_W+GRID_H_BITS-1:FRAC_W];
        bx   <= $signed({2'b00, gx[FRAC_W+GRID_W_BITS-1:FRAC_W]}) -
                $signed({{(CELL_W-1){1'b0}}, ~x_beyond});
        by   <= $signed({2'b00, gy[FRAC_W+GRID_H_BITS-1:FRAC_W]}) -
                $signed({{(CELL_W-1){1'b0}}, ~y_beyond});
        tx   <= x_beyond ? {1'b0, gx[FRAC_W-1:0]} - HALF_Q16
                         : {1'b0, gx[FRAC_W-1:0]} + HALF_Q16;
        ty   <= y_beyond ? {1'b0, gy[FRAC_W-1:0]} - HALF_Q16
                         : {1'b0, gy[FRAC_W-1:0]} + HALF_Q16;
        nb_k <= '0;
        sum  <= '0;
        wsum <= '0;
      end
      ST_NB_ADDR: begin
        nb_in <= (nx[CELL_W-1:GRID_W_BITS] == '0) && (ny[CELL_W-1:GRID_H_BITS] == '0);
      end
      ST_NB_READ: begin
        nb_use  <= nb_in && (mem_rdata != unreached_distance);
        nb_dist <= mem_rdata;
      end
      ST_NB_WMUL: begin
        weight <= prod[W_W-1:0];
      end
      ST_NB_ACC: begin
        if (nb_use) begin
          sum  <= sum + prod[SUM_W-1:0];
          wsum <= wsum + weight;
        end
        nb_k <= nb_k + 2'd1;
      end
      ST_CENTER: begin
        result <= mem_rdata;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          result <= div_quot;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= result;
    end
  end

  // the divider only starts with a nonzero weight sum
  a_div_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (wsum != '0))
    else $error("divider started with zero weight sum");

  // bilinear weights of one query never add up to more than one in Q.32
  a_wsum_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (wsum <= W_W'(1) << (2 * FRAC_W)))
    else $error("weight sum exceeds unity");

  // no transaction is taken while a division is running
  a_no_accept_in_divide: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_stat.busy)
    else $error("input ready during division");

  // a division finishing always hands its quotient to the output path
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIVIDE) ##1 (state == ST_DONE))
    else $error("division finished outside the divide step");

endmodule
